// ===== hdl/df_pkg.sv =====
// ----------------------------------------------------------------------------
// Drag force package
// Shared widths, defaults and register indexes for the drag force block.
// ----------------------------------------------------------------------------
`default_nettype none

package df_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned SQ_W          = 2 * DATA_W;
    localparam int unsigned ROOT_W        = DATA_W;
    localparam int unsigned REM_W         = DATA_W + 3;
    localparam int unsigned ADDR_W        = 3;

    typedef enum logic [0:0] {
        REG_LINEAR = 1'b0,
        REG_QUAD   = 1'b1
    } reg_idx_t;

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hdl/df_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage,
// with a side payload that travels alongside the data.
// ----------------------------------------------------------------------------
`default_nettype none

module df_isqrt #(
    parameter int unsigned PAY_W = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [df_pkg::SQ_W-1:0]       in_n,
    input  wire logic [PAY_W-1:0]              in_pay,
    output logic                               out_valid,
    output logic [df_pkg::ROOT_W-1:0]          out_root,
    output logic [PAY_W-1:0]                   out_pay
);

    localparam int unsigned STEPS = df_pkg::ROOT_W;
    localparam int unsigned SW    = df_pkg::SQ_W;
    localparam int unsigned RW    = df_pkg::REM_W;
    localparam int unsigned TW    = df_pkg::ROOT_W;

    logic          valid_reg [0:STEPS-1];
    logic [SW-1:0] n_reg     [0:STEPS-1];
    logic [RW-1:0] rem_reg   [0:STEPS-1];
    logic [TW-1:0] root_reg  [0:STEPS-1];
    logic [PAY_W-1:0] pay_reg [0:STEPS-1];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic          v_in;
            logic [SW-1:0] n_in;
            logic [RW-1:0] rem_in;
            logic [TW-1:0] root_in;
            logic [PAY_W-1:0] pay_in;
            logic [RW-1:0] rem_sh;
            logic [RW-1:0] trial;
            logic          ge;
            logic [RW-1:0] rem_next;
            logic [TW-1:0] root_next;
            logic [SW-1:0] n_next;

            if (k == 0) begin : g_first
                assign v_in    = in_valid;
                assign n_in    = in_n;
                assign rem_in  = '0;
                assign root_in = '0;
                assign pay_in  = in_pay;
            end else begin : g_rest
                assign v_in    = valid_reg[k-1];
                assign n_in    = n_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign pay_in  = pay_reg[k-1];
            end

            always_comb
            begin
                rem_sh    = {rem_in[RW-3:0], n_in[SW-1:SW-2]};
                trial     = {1'b0, root_in, 2'b01};
                ge        = (rem_sh >= trial);
                rem_next  = ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_in[TW-2:0], ge};
                n_next    = {n_in[SW-3:0], 2'b00};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k]    <= n_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    pay_reg[k]  <= pay_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_pay   = pay_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/drag_force.sv =====
// ----------------------------------------------------------------------------
// Drag force
// Linear plus quadratic drag, F = -v * (k1 + k2*|v|), in signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one velocity per cycle while the output is accepted, and
// returns one force per velocity, in order, after registered stages for
// magnitudes, squares and their sum, one square root stage per result bit,
// and stages for the coefficient product, the coefficient sum, the component
// products and saturation. When the output transfer is held off, the whole
// pipeline holds. Force components that leave the 32-bit range saturate and
// set the overflow flag in tuser.
`default_nettype none

module drag_force #(
    parameter int unsigned FRAC_BITS = df_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [df_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [95:0]                 s_tdata,   // vel_x, vel_y, vel_z
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [95:0]                 m_tdata,   // force_x, force_y, force_z
    output logic      [0:0]                  m_tuser    // overflow
);

    localparam int unsigned DW    = df_pkg::DATA_W;
    localparam int unsigned SW    = df_pkg::SQ_W;
    localparam int unsigned KQ_W  = SW - FRAC_BITS;
    localparam int unsigned FW    = KQ_W + 1;
    localparam int unsigned FH    = FW - DW;
    localparam int unsigned P_W   = DW + FW;
    localparam int unsigned Q_W   = P_W - FRAC_BITS;
    localparam int unsigned PAY_W = 3 * DW + 3;

    logic [DW-1:0] linear_coeff_reg;
    logic [DW-1:0] quadratic_coeff_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_coeff_reg    <= '0;
            quadratic_coeff_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (df_pkg::reg_idx_t'(paddr[2]))
                df_pkg::REG_LINEAR: linear_coeff_reg    <= pwdata;
                df_pkg::REG_QUAD:   quadratic_coeff_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (df_pkg::reg_idx_t'(paddr[2]))
            df_pkg::REG_LINEAR: prdata = linear_coeff_reg;
            df_pkg::REG_QUAD:   prdata = quadratic_coeff_reg;
            default:            prdata = '0;
        endcase
    end

    logic en;
    assign en       = m_tready | ~m_tvalid;
    assign s_tready = en;

    // Stage 0: magnitudes and signs.
    logic          v0_reg;
    logic [DW-1:0] mag0_reg [0:2];
    logic [2:0]    neg0_reg;
    // Stage 1: squares.
    logic          v1_reg;
    logic [SW-1:0] sq1_reg  [0:2];
    logic [DW-1:0] mag1_reg [0:2];
    logic [2:0]    neg1_reg;
    // Stage 2: sum of squares.
    logic          v2_reg;
    logic [SW-1:0] ss2_reg;
    logic [DW-1:0] mag2_reg [0:2];
    logic [2:0]    neg2_reg;
    // Square root output.
    logic             vq;
    logic [DW-1:0]    root_q;
    logic [PAY_W-1:0] pay_q;
    // Stage 3: k2 * root.
    logic          v3_reg;
    logic [SW-1:0] kq3_reg;
    logic [PAY_W-1:0] pay3_reg;
    // Stage 4: coefficient sum.
    logic          v4_reg;
    logic [FW-1:0] f4_reg;
    logic [PAY_W-1:0] pay4_reg;
    // Stage 5: partial products.
    logic          v5_reg;
    logic [SW-1:0]     plo5_reg [0:2];
    logic [DW+FH-1:0]  phi5_reg [0:2];
    logic [2:0]        neg5_reg;
    // Stage 6: output.
    logic [DW-1:0] force_reg [0:2];
    logic          ovf_reg;
    logic          vout_reg;

    logic [PAY_W-1:0] pay2;
    logic [DW-1:0]    mag_q  [0:2];
    logic [FW-1:0]    f_next;
    logic [DW-1:0]    force_next [0:2];
    logic [2:0]       sat_next;

    always_comb
    begin
        pay2 = {neg2_reg, mag2_reg[2], mag2_reg[1], mag2_reg[0]};
        for (int i = 0; i < 3; i++)
        begin
            mag_q[i] = pay_q[i*DW +: DW];
        end
    end

    always_comb
    begin
        f_next = {1'b0, kq3_reg[SW-1:FRAC_BITS]} + {{FH{1'b0}}, linear_coeff_reg};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [P_W-1:0] p;
            logic [Q_W-1:0] q;
            logic           hi_nz;
            p     = {{FH{1'b0}}, plo5_reg[i]} + {phi5_reg[i], {DW{1'b0}}};
            q     = p[P_W-1:FRAC_BITS];
            hi_nz = |q[Q_W-1:DW];
            if (neg5_reg[i])
            begin
                sat_next[i]   = hi_nz | q[DW-1];
                force_next[i] = sat_next[i] ? df_pkg::POS_MAX : q[DW-1:0];
            end
            else
            begin
                sat_next[i]   = hi_nz | (q[DW-1:0] > df_pkg::NEG_MIN);
                force_next[i] = sat_next[i] ? df_pkg::NEG_MIN : (~q[DW-1:0] + 1'b1);
            end
        end
    end

    df_isqrt #(
        .PAY_W (PAY_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_n      (ss2_reg),
        .in_pay    (pay2),
        .out_valid (vq),
        .out_root  (root_q),
        .out_pay   (pay_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= s_tvalid;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= vq;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vout_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= s_tdata[i*DW + DW - 1];
                mag0_reg[i] <= s_tdata[i*DW + DW - 1] ? (~s_tdata[i*DW +: DW] + 1'b1)
                                                      : s_tdata[i*DW +: DW];
                sq1_reg[i]  <= mag0_reg[i] * mag0_reg[i];
                mag1_reg[i] <= mag0_reg[i];
                mag2_reg[i] <= mag1_reg[i];
                plo5_reg[i] <= pay4_reg[i*DW +: DW] * f4_reg[DW-1:0];
                phi5_reg[i] <= pay4_reg[i*DW +: DW] * f4_reg[FW-1:DW];
                force_reg[i] <= force_next[i];
            end
            neg1_reg <= neg0_reg;
            neg2_reg <= neg1_reg;
            ss2_reg  <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            kq3_reg  <= quadratic_coeff_reg * root_q;
            pay3_reg <= pay_q;
            f4_reg   <= f_next;
            pay4_reg <= pay3_reg;
            neg5_reg <= pay4_reg[3*DW +: 3];
            ovf_reg  <= |sat_next;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = {force_reg[2], force_reg[1], force_reg[0]};
    assign m_tuser  = ovf_reg;

    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (vq && mag_q[0] == '0 && mag_q[1] == '0 && mag_q[2] == '0) |-> (root_q == '0))
        else $error("square root of a zero velocity is not zero");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (force_reg[0] == df_pkg::POS_MAX || force_reg[0] == df_pkg::NEG_MIN ||
             force_reg[1] == df_pkg::POS_MAX || force_reg[1] == df_pkg::NEG_MIN ||
             force_reg[2] == df_pkg::POS_MAX || force_reg[2] == df_pkg::NEG_MIN))
        else $error("overflow flagged without a saturated component");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && neg5_reg[0]) |-> !force_next[0][DW-1])
        else $error("negative velocity gave a negative force");

endmodule

`default_nettype wire

// ===== verif/drag_force_checker.sv =====
// ----------------------------------------------------------------------------
// Drag force checker
// Watches the velocity and force streams and the register port, predicts each
// force from the accepted velocity and the current coefficients, and compares
// the output transfers in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module drag_force_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [df_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    input  wire logic                      pready,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [95:0]               s_tdata,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [95:0]               m_tdata,
    input  wire logic [0:0]                m_tuser,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = df_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic        ovf;
        logic [95:0] force_v;
    } force_t;

    logic [31:0] k_lin;
    logic [31:0] k_quad;
    force_t      force_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic force_t drag_of(input logic [95:0] vel);
        logic [31:0]  mag[3];
        logic         neg[3];
        logic [63:0]  s2;
        logic [63:0]  spd;
        logic [127:0] fac;
        logic [127:0] p;
        logic [31:0]  cap;
        force_t       res;
        s2 = '0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = vel[32*i+31];
            mag[i] = neg[i] ? -vel[32*i +: 32] : vel[32*i +: 32];
            s2 += 64'(mag[i]) * 64'(mag[i]);
        end
        spd = int_sqrt(s2);
        fac = 128'(k_lin) + ((128'(k_quad) * 128'(spd)) >> FB);
        for (int i = 0; i < 3; i++) begin
            p = (128'(mag[i]) * fac) >> FB;
            cap = neg[i] ? df_pkg::POS_MAX : df_pkg::NEG_MIN;
            if (p > 128'(cap))
            begin
                p = 128'(cap);
                res.ovf = 1'b1;
            end
            res.force_v[32*i +: 32] = neg[i] ? p[31:0] : -p[31:0];
        end
        return res;
    endfunction

    assign pending = force_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        force_t want;
        int     n_err;
        if (!rst_n)
        begin
            k_lin  <= '0;
            k_quad <= '0;
            errors <= 0;
            force_q.delete();
        end
        else
        begin
            n_err = 0;
            if (m_tvalid && m_tready)
            begin
                if (force_q.size() == 0)
                begin
                    $display("%0t: unexpected force transfer %h / %b", $time, m_tdata, m_tuser);
                    n_err++;
                end
                else
                begin
                    want = force_q.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (m_tdata[32*i +: 32] !== want.force_v[32*i +: 32])
                        begin
                            $display("%0t: force[%0d] expected %h actual %h", $time, i,
                                     want.force_v[32*i +: 32], m_tdata[32*i +: 32]);
                            n_err++;
                        end
                    if (m_tuser[0] !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want.ovf, m_tuser[0]);
                        n_err++;
                    end
                end
            end
            if (n_err != 0)
                errors <= errors + n_err;
            if (s_tvalid && s_tready)
                force_q.push_back(drag_of(s_tdata));
            if (psel && penable && pwrite && pready)
                case (df_pkg::reg_idx_t'(paddr[2]))
                    df_pkg::REG_LINEAR: k_lin  <= pwdata;
                    df_pkg::REG_QUAD:   k_quad <= pwdata;
                    default: ;
                endcase
        end
    end
endmodule

`default_nettype wire

// ===== verif/tb_drag_force.sv =====
// ----------------------------------------------------------------------------
// Drag force testbench
// Drives velocities through the drag force block under several coefficient
// settings, with random gaps on both streams and one long output hold-off,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_drag_force;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [df_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [95:0]                 s_tdata;   // vel_x, vel_y, vel_z
    logic                        m_tvalid;
    logic                        m_tready;
    logic [95:0]                 m_tdata;   // force_x, force_y, force_z
    logic [0:0]                  m_tuser;   // overflow
    int                          errors;
    int                          pending;
    bit                          gaps_on;
    bit                          hold_req;

    drag_force dut (.*);

    drag_force_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("FAIL drag_force");
        $finish;
    end

    task automatic write_reg(input df_pkg::reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= df_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh1_FFFF);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_vel(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz);
        int g;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int g;
        m_tready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                g = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [31:0] k1_set[6];
        logic [31:0] k2_set[6];
        logic [31:0] edges[5];
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        gaps_on  = 1'b0;
        hold_req = 1'b0;
        k1_set = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 32'h0003_4000};
        k2_set = '{32'h0000_0100, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000, 32'h0000_0040};
        edges  = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-axis and mixed extremes.
        write_reg(df_pkg::REG_LINEAR, k1_set[0]);
        write_reg(df_pkg::REG_QUAD, k2_set[0]);
        foreach (edges[i])
            send_vel(edges[i], edges[(i + 1) % 5], edges[(i + 3) % 5]);
        send_vel(32'h0001_0000, 32'h0, 32'h0);
        send_vel(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_vel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003);
        drain();

        gaps_on = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(df_pkg::REG_LINEAR, k1_set[ph]);
            write_reg(df_pkg::REG_QUAD, k2_set[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 5)
                gaps_on = 1'b0;
            for (int n = 0; n < 140; n++)
                send_vel(rand_comp(), rand_comp(), rand_comp());
            drain();
        end

        if (errors == 0)
            $display("PASS drag_force");
        else
            $display("FAIL drag_force");
        $finish;
    end
endmodule

`default_nettype wire
